@@ sv/gov_pkg.sv @@
// Shared types and constants of the load based frequency governor.
// No dependencies; gov_front and the top module import this package.
`default_nettype none
package gov_pkg;
	localparam int unsigned FW = 32;              // field width of samples and frequencies
	localparam int unsigned SW = 25;              // width of busy/total after range reduction
	localparam logic [31:0] PCT_FULL = 32'd100;
	localparam logic [31:0] SCALE_LIMIT = 32'h0100_0000;
	localparam int unsigned SCALE_SHIFT = 7;
	localparam logic [7:0] DEFAULT_UP = 8'd90;
	localparam logic [7:0] DEFAULT_DOWN = 8'd5;

	typedef enum logic [1:0] {
		CFG_UP_THRESHOLD = 2'd0,
		CFG_DOWN_DIFF    = 2'd1,
		CFG_MIN_FREQ     = 2'd2,
		CFG_MAX_FREQ     = 2'd3
	} gov_cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_INVALID = 2'd0,
		KIND_MAX     = 2'd1,
		KIND_HOLD    = 2'd2,
		KIND_SCALE   = 2'd3
	} gov_kind_t;

	typedef struct packed {
		logic [7:0] up;
		logic [7:0] down;
		logic       invalid;
		logic [6:0] divisor;
	} gov_cfg_t;

	typedef struct packed {
		gov_kind_t       kind;
		logic [FW-1:0]   cur;
		logic [SW+FW-1:0] prod;
		logic [SW-1:0]   total;
	} gov_front_t;
endpackage
`default_nettype wire

@@ sv/gov_sample_if.sv @@
// Request channel carrying one load sample.
// Depends on nothing.
`default_nettype none
interface gov_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] busy_cnt;
	logic [31:0] window_cnt;
	logic [31:0] cur_freq;
	modport source(output valid, busy_cnt, window_cnt, cur_freq, input ready);
	modport sink(input valid, busy_cnt, window_cnt, cur_freq, output ready);
endinterface
`default_nettype wire

@@ sv/gov_result_if.sv @@
// Result channel carrying the target frequency and status.
// Depends on nothing.
`default_nettype none
interface gov_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] target_frequency;
	logic        status;
	modport source(output valid, target_frequency, status, input ready);
	modport sink(input valid, target_frequency, status, output ready);
endinterface
`default_nettype wire

@@ sv/load_based_frequency_governor.sv @@
// Load based frequency governor: sample in, target frequency out.
// Pipeline from request to result register: 3 front, 32 + 39 divider stages,
// 1 multiply, 1 clamp/output; throughput one request per cycle unless the output stalls.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Async active-low reset clears valid bits and all config registers to zero.
`default_nettype none
module load_based_frequency_governor #(
	parameter int unsigned FREQ_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	gov_sample_if.sink       in_if,
	gov_result_if.source     out_if
);
	import gov_pkg::*;

	// saturation ceiling for the scaled result
	localparam logic [63:0] TOP = {64{1'b1}} >> (64 - FREQ_BITS);

	logic [7:0]  up_q, down_q;
	logic [31:0] min_q, max_q;
	gov_cfg_t    cfg;
	logic [63:0] maxf;
	logic        en;

	// config registers; write them only while the pipeline is empty (the block does not enforce it)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q   <= '0;
			down_q <= '0;
			min_q  <= '0;
			max_q  <= '0;
		end else if (cfg_we) begin
			unique case (gov_cfg_idx_t'(cfg_index))
				CFG_UP_THRESHOLD: up_q   <= cfg_data[7:0];
				CFG_DOWN_DIFF:    down_q <= cfg_data[7:0];
				CFG_MIN_FREQ:     min_q  <= cfg_data;
				CFG_MAX_FREQ:     max_q  <= cfg_data;
			endcase
		end
	end

	// effective thresholds, validity and the second divisor
	always_comb begin
		logic [7:0] d;
		cfg.up      = (up_q == '0) ? DEFAULT_UP : up_q;
		cfg.down    = (down_q == '0) ? DEFAULT_DOWN : down_q;
		cfg.invalid = (cfg.up > 8'(PCT_FULL)) || (cfg.up < cfg.down);
		d           = cfg.up - (cfg.down >> 1);
		cfg.divisor = (d[6:0] == '0) ? 7'd1 : d[6:0];
	end

	assign maxf = (max_q == '0) ? TOP : 64'(max_q);

	// advance everything unless the result register is held
	logic out_valid_q;
	assign en          = !out_valid_q || out_if.ready;
	assign in_if.ready = en;

	// front: range reduction, products, branch choice
	logic       fr_valid;
	gov_front_t fr;

	gov_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_if.valid),
		.busy     (in_if.busy_cnt),
		.total    (in_if.window_cnt),
		.cur      (in_if.cur_freq),
		.cfg      (cfg),
		.out_valid(fr_valid),
		.out      (fr)
	);

	// busy*cur / total; quotient fits 32 bits on the scaling branch
	logic          d1_valid;
	logic [31:0]   d1_quot;
	logic [33:0]   d1_side;

	gov_div #(.QW(32), .DW(SW), .XW(34)) u_div_load (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (fr_valid),
		.in_hi    (fr.prod[SW+31:32]),
		.in_lo    (fr.prod[31:0]),
		.divisor  (fr.total),
		.in_side  ({fr.kind, fr.cur}),
		.out_valid(d1_valid),
		.out_quot (d1_quot),
		.out_side (d1_side)
	);

	// times one hundred
	logic        mul_valid_s1;
	logic [38:0] mul_s1;
	logic [33:0] mul_side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_valid_s1 <= 1'b0;
		end else if (en) begin
			mul_valid_s1 <= d1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1      <= 39'(d1_quot) * 39'(PCT_FULL);
			mul_side_s1 <= d1_side;
		end
	end

	// divide by up - down/2
	logic        d2_valid;
	logic [38:0] d2_quot;
	logic [33:0] d2_side;

	gov_div #(.QW(39), .DW(7), .XW(34)) u_div_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (mul_valid_s1),
		.in_hi    (7'd0),
		.in_lo    (mul_s1),
		.divisor  (cfg.divisor),
		.in_side  (mul_side_s1),
		.out_valid(d2_valid),
		.out_quot (d2_quot),
		.out_side (d2_side)
	);

	// saturate, clamp and select the branch result
	gov_kind_t   kind;
	logic [31:0] cur;
	logic [63:0] res;
	logic [31:0] tf_d;
	logic        st_d;

	assign kind = gov_kind_t'(d2_side[33:32]);
	assign cur  = d2_side[31:0];

	always_comb begin
		res = 64'(d2_quot);
		if (res > TOP) res = TOP;
		if ((min_q != '0) && (res < 64'(min_q))) res = 64'(min_q);
		if ((max_q != '0) && (res > 64'(max_q))) res = 64'(max_q);
		st_d = 1'b0;
		unique case (kind)
			KIND_INVALID: begin
				tf_d = '0;
				st_d = 1'b1;
			end
			KIND_MAX:   tf_d = maxf[31:0];
			KIND_HOLD:  tf_d = cur;
			KIND_SCALE: tf_d = res[31:0];
		endcase
	end

	logic [31:0] tf_q;
	logic        st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_q <= tf_d;
			st_q <= st_d;
		end
	end

	assign out_if.valid            = out_valid_q;
	assign out_if.target_frequency = tf_q;
	assign out_if.status           = st_q;

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && st_q |-> tf_q == '0)
		else $error("invalid status with nonzero frequency");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_if.ready |-> out_valid_q && !out_if.ready)
		else $error("request refused without a held result");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_if.ready |=> out_valid_q && $stable(tf_q))
		else $error("held result dropped or changed");
endmodule
`default_nettype wire

@@ sv/gov_front.sv @@
// Front end: range reduction, load products and branch decision, three stages.
// Depends on gov_pkg.
`default_nettype none
module gov_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [31:0]                   busy,
	input  wire logic [31:0]                   total,
	input  wire logic [31:0]                   cur,
	input  wire gov_pkg::gov_cfg_t             cfg,
	output logic                               out_valid,
	output gov_pkg::gov_front_t                out
);
	import gov_pkg::*;

	logic            valid_s1, valid_s2, valid_s3;
	logic [SW-1:0]   busy_s1, total_s1, total_s2;
	logic [FW-1:0]   cur_s1, cur_s2;
	logic            tzero_s1, tzero_s2;
	logic [31:0]     b100_s2;
	logic [32:0]     tu_s2, tud_s2;
	logic [SW+FW-1:0] prod_s2;
	gov_front_t      out_s3;
	logic            wide_win;
	gov_kind_t       kind;

	assign wide_win = (busy >= SCALE_LIMIT) || (total >= SCALE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: bring large windows into range
	always_ff @(posedge clk) begin
		if (en) begin
			busy_s1  <= wide_win ? SW'(busy >> SCALE_SHIFT) : SW'(busy);
			total_s1 <= wide_win ? SW'(total >> SCALE_SHIFT) : SW'(total);
			cur_s1   <= cur;
			tzero_s1 <= (total == 32'd0);
		end
	end

	// stage 2: load products
	always_ff @(posedge clk) begin
		if (en) begin
			b100_s2  <= 32'(busy_s1) * PCT_FULL;
			tu_s2    <= 33'(total_s1) * 33'(cfg.up);
			tud_s2   <= 33'(total_s1) * 33'(cfg.up - cfg.down);
			prod_s2  <= (SW+FW)'(busy_s1) * (SW+FW)'(cur_s1);
			total_s2 <= total_s1;
			cur_s2   <= cur_s1;
			tzero_s2 <= tzero_s1;
		end
	end

	// stage 3: pick the branch
	always_comb begin
		priority if (cfg.invalid)                    kind = KIND_INVALID;
		else if (tzero_s2)                           kind = KIND_MAX;
		else if (33'(b100_s2) > tu_s2)               kind = KIND_MAX;
		else if (cur_s2 == '0)                       kind = KIND_MAX;
		else if (33'(b100_s2) > tud_s2)              kind = KIND_HOLD;
		else if (total_s2 == '0)                     kind = KIND_MAX;
		else                                         kind = KIND_SCALE;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_s3.kind  <= kind;
			out_s3.cur   <= cur_s2;
			out_s3.prod  <= prod_s2;
			out_s3.total <= total_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out       = out_s3;
endmodule
`default_nettype wire

@@ sv/gov_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing; the dividend high part must stay below the divisor.
`default_nettype none
module gov_div #(
	parameter int unsigned QW = 32,
	parameter int unsigned DW = 25,
	parameter int unsigned XW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] in_hi,
	input  wire logic [QW-1:0] in_lo,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [XW-1:0] in_side,
	output logic               out_valid,
	output logic [QW-1:0]      out_quot,
	output logic [XW-1:0]      out_side
);
	logic          v_s   [0:QW];
	logic [DW-1:0] rem_s [0:QW];
	logic [QW-1:0] lo_s  [0:QW];
	logic [DW-1:0] div_s [0:QW];
	logic [XW-1:0] side_s[0:QW];

	assign v_s[0]    = in_valid;
	assign rem_s[0]  = in_hi;
	assign lo_s[0]   = in_lo;
	assign div_s[0]  = divisor;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [DW:0]   diff;

		assign trial = {rem_s[k], lo_s[k][QW-1]};
		assign ge    = trial >= {1'b0, div_s[k]};
		assign diff  = trial - {1'b0, div_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				lo_s[k+1]   <= {lo_s[k][QW-2:0], ge};
				div_s[k+1]  <= div_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign out_quot  = lo_s[QW];
	assign out_side  = side_s[QW];
endmodule
`default_nettype wire
